// ===== rtl/fraction_sum_lcd_top_assert.svh =====
// assertion macros used by the checker file
`ifndef FRACTION_SUM_LCD_TOP_ASSERT_SVH
`define FRACTION_SUM_LCD_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FSL_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FSL_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== rtl/fsl_pkg.sv =====
// shared constants, state encoding and control structs for the fraction adder
package fsl_pkg;

   localparam int NUMERATOR_BITS   = 16;
   localparam int DENOMINATOR_BITS = 16;
   localparam int SUM_BITS         = NUMERATOR_BITS + DENOMINATOR_BITS + 1;
   localparam int LCD_BITS         = 2 * DENOMINATOR_BITS;
   localparam int MUL_A_BITS       = ((NUMERATOR_BITS > DENOMINATOR_BITS) ?
                                      NUMERATOR_BITS : DENOMINATOR_BITS) + 1;
   localparam int MUL_B_BITS       = DENOMINATOR_BITS + 1;
   localparam int PROD_BITS        = MUL_A_BITS + MUL_B_BITS;
   localparam int CNT_BITS         = $clog2(DENOMINATOR_BITS);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_GCD,
      ST_DIV1,
      ST_SAVE1,
      ST_DIV2,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_N1_S1,
      MUL_N2_S2,
      MUL_S2_D2
   } mul_sel_type;

   typedef enum logic {
      DIVIDEND_D2,
      DIVIDEND_D1
   } dividend_sel_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic             load;
      logic             gcd_step;
      logic             gcd_finish;
      logic             div_init;
      dividend_sel_type div_sel;
      logic             div_step;
      logic             save_s1;
      logic             save_s2;
      logic             mul_en;
      mul_sel_type      mul_sel;
      logic             acc_clear;
      logic             acc_add;
      logic             out_load;
   } ctrl_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic zero_den;
      logic gcd_done;
      logic div_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== rtl/fsl_ctrl.sv =====
// sequencing state machine: gcd, two divisions, three multiplies, result load
module fsl_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  fsl_pkg::dp_status_type status,
   output fsl_pkg::ctrl_cmd_type  cmd
);
   import fsl_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = status.zero_den ? ST_FINISH : ST_GCD;
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               state_in = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (status.div_last) begin
               state_in = ST_SAVE1;
            end
         end
         ST_SAVE1: begin
            state_in = ST_DIV2;
         end
         ST_DIV2: begin
            if (status.div_last) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_stall = (state_ff != ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load = req_valid;
         end
         ST_START: begin
         end
         ST_GCD: begin
            cmd.gcd_step   = !status.gcd_done;
            cmd.gcd_finish = status.gcd_done;
            cmd.div_init   = status.gcd_done;
            cmd.div_sel    = DIVIDEND_D2;
         end
         ST_DIV1: begin
            cmd.div_step = 1'b1;
         end
         ST_SAVE1: begin
            cmd.save_s1  = 1'b1;
            cmd.div_init = 1'b1;
            cmd.div_sel  = DIVIDEND_D1;
         end
         ST_DIV2: begin
            cmd.div_step = 1'b1;
         end
         ST_MUL1: begin
            cmd.save_s2 = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_N1_S1;
         end
         ST_MUL2: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_sel   = MUL_N2_S2;
            cmd.acc_clear = 1'b1;
            cmd.acc_add   = 1'b1;
         end
         ST_MUL3: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_S2_D2;
            cmd.acc_add = 1'b1;
         end
         ST_FINISH: begin
            cmd.out_load = status.out_free;
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/fsl_datapath.sv =====
// operand registers, binary gcd, restoring divider, shared multiplier, output word
module fsl_datapath (
   input  logic                                          clock,
   input  logic                                          reset,
   input  fsl_pkg::ctrl_cmd_type                         cmd,
   output fsl_pkg::dp_status_type                        status,
   input  logic signed [fsl_pkg::NUMERATOR_BITS-1:0]     req_first_numerator,
   input  logic        [fsl_pkg::DENOMINATOR_BITS-1:0]   req_first_denominator,
   input  logic signed [fsl_pkg::NUMERATOR_BITS-1:0]     req_second_numerator,
   input  logic        [fsl_pkg::DENOMINATOR_BITS-1:0]   req_second_denominator,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic signed [fsl_pkg::SUM_BITS-1:0]           rsp_sum_numerator,
   output logic        [fsl_pkg::LCD_BITS-1:0]           rsp_common_denominator,
   output logic                                          rsp_zero_denominator_error
);
   import fsl_pkg::*;

   // captured operands
   logic signed [NUMERATOR_BITS-1:0]   n1_ff, n2_ff;
   logic        [DENOMINATOR_BITS-1:0] d1_ff, d2_ff;
   logic                               zero_ff;

   // gcd working registers
   logic [DENOMINATOR_BITS-1:0] a_ff, a_in;
   logic [DENOMINATOR_BITS-1:0] b_ff, b_in;
   logic [CNT_BITS-1:0]         k_ff, k_in;
   logic [DENOMINATOR_BITS-1:0] g_ff;
   logic [DENOMINATOR_BITS-1:0] a_minus_b, b_minus_a;

   // divider registers
   logic [DENOMINATOR_BITS-1:0] rem_ff, rem_in;
   logic [DENOMINATOR_BITS-1:0] quo_ff, quo_in;
   logic [CNT_BITS-1:0]         cnt_ff;
   logic [DENOMINATOR_BITS:0]   rem_shift, rem_diff;
   logic [DENOMINATOR_BITS-1:0] s1_ff, s2_ff;

   // multiplier and accumulator
   logic signed [MUL_A_BITS-1:0] mul_a;
   logic signed [MUL_B_BITS-1:0] mul_b;
   logic signed [PROD_BITS-1:0]  prod_in, prod_ff;
   logic signed [SUM_BITS-1:0]   acc_ff, acc_in;

   // output word
   logic                       out_valid_ff;
   logic signed [SUM_BITS-1:0] out_sum_ff;
   logic        [LCD_BITS-1:0] out_lcd_ff;
   logic                       out_err_ff;

   // operand capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         n1_ff   <= req_first_numerator;
         n2_ff   <= req_second_numerator;
         d1_ff   <= req_first_denominator;
         d2_ff   <= req_second_denominator;
         zero_ff <= (req_first_denominator == '0) || (req_second_denominator == '0);
      end
   end

   // binary gcd step: strip common twos, then halve or subtract odd pairs
   assign a_minus_b = a_ff - b_ff;
   assign b_minus_a = b_ff - a_ff;

   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      k_in = k_ff;
      priority if (!a_ff[0] && !b_ff[0]) begin
         a_in = a_ff >> 1;
         b_in = b_ff >> 1;
         k_in = k_ff + 1'b1;
      end else if (!a_ff[0]) begin
         a_in = a_ff >> 1;
      end else if (!b_ff[0]) begin
         b_in = b_ff >> 1;
      end else if (a_ff > b_ff) begin
         a_in = a_minus_b >> 1;
      end else begin
         b_in = b_minus_a >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= req_first_denominator;
         b_ff <= req_second_denominator;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         a_ff <= a_in;
         b_ff <= b_in;
         k_ff <= k_in;
      end
      if (cmd.gcd_finish) begin
         g_ff <= a_ff << k_ff;
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_shift = {rem_ff, quo_ff[DENOMINATOR_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, g_ff};

   always_comb begin
      if (!rem_diff[DENOMINATOR_BITS]) begin
         rem_in = rem_diff[DENOMINATOR_BITS-1:0];
         quo_in = {quo_ff[DENOMINATOR_BITS-2:0], 1'b1};
      end else begin
         rem_in = rem_shift[DENOMINATOR_BITS-1:0];
         quo_in = {quo_ff[DENOMINATOR_BITS-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= '0;
         quo_ff <= (cmd.div_sel == DIVIDEND_D2) ? d2_ff : d1_ff;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (cmd.save_s1) begin
         s1_ff <= quo_ff;
      end
      if (cmd.save_s2) begin
         s2_ff <= quo_ff;
      end
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.mul_sel)
         MUL_N1_S1: begin
            mul_a = MUL_A_BITS'(n1_ff);
            mul_b = {1'b0, s1_ff};
         end
         MUL_N2_S2: begin
            mul_a = MUL_A_BITS'(n2_ff);
            mul_b = {1'b0, s2_ff};
         end
         MUL_S2_D2: begin
            mul_a = $signed({{(MUL_A_BITS - DENOMINATOR_BITS){1'b0}}, s2_ff});
            mul_b = {1'b0, d2_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // s2 is saved in the same cycle as the first multiply, which does not use it
   assign prod_in = mul_a * mul_b;
   assign acc_in  = (cmd.acc_clear ? SUM_BITS'(0) : acc_ff) + prod_ff[SUM_BITS-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_in;
      end
      if (cmd.acc_add) begin
         acc_ff <= acc_in;
      end
   end

   // output word register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_err_ff <= zero_ff;
         out_sum_ff <= zero_ff ? SUM_BITS'(0) : acc_ff;
         out_lcd_ff <= zero_ff ? LCD_BITS'(0) : prod_ff[LCD_BITS-1:0];
      end
   end

   // status back to the controller
   always_comb begin
      status.zero_den = zero_ff;
      status.gcd_done = (a_ff == b_ff);
      status.div_last = (cnt_ff == CNT_BITS'(DENOMINATOR_BITS - 1));
      status.out_free = !out_valid_ff || !rsp_stall;
   end

   assign rsp_valid                  = out_valid_ff;
   assign rsp_sum_numerator          = out_sum_ff;
   assign rsp_common_denominator     = out_lcd_ff;
   assign rsp_zero_denominator_error = out_err_ff;

endmodule

// ===== rtl/fraction_sum_lcd_top.sv =====
// top level of the fraction adder over the least common denominator
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  two numerators, two denominators
//   rsp      out        rsp_valid / rsp_stall  sum numerator, lcd, zero flag
//
// one word at a time; a word with a zero denominator goes from its start state straight to
// the result load, otherwise it runs the gcd steps (at most 2*16, one per cycle), then two
// restoring divisions and three passes through one multiplier
// the result sits in an output register, so the next word is taken while it waits
// reset is synchronous and clears only the controller state and the output valid
// a stalled result holds; a finished word waits in its last state until the
// output register is free
module fraction_sum_lcd_top (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic signed [fsl_pkg::NUMERATOR_BITS-1:0]     req_first_numerator,
   input  logic        [fsl_pkg::DENOMINATOR_BITS-1:0]   req_first_denominator,
   input  logic signed [fsl_pkg::NUMERATOR_BITS-1:0]     req_second_numerator,
   input  logic        [fsl_pkg::DENOMINATOR_BITS-1:0]   req_second_denominator,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic signed [fsl_pkg::SUM_BITS-1:0]           rsp_sum_numerator,
   output logic        [fsl_pkg::LCD_BITS-1:0]           rsp_common_denominator,
   output logic                                          rsp_zero_denominator_error
);
   import fsl_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   // sequencer
   fsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and result register
   fsl_datapath u_datapath (
      .clock                      (clock),
      .reset                      (reset),
      .cmd                        (cmd),
      .status                     (status),
      .req_first_numerator        (req_first_numerator),
      .req_first_denominator      (req_first_denominator),
      .req_second_numerator       (req_second_numerator),
      .req_second_denominator     (req_second_denominator),
      .rsp_valid                  (rsp_valid),
      .rsp_stall                  (rsp_stall),
      .rsp_sum_numerator          (rsp_sum_numerator),
      .rsp_common_denominator     (rsp_common_denominator),
      .rsp_zero_denominator_error (rsp_zero_denominator_error)
   );

endmodule

// ===== rtl/fsl_checker.sv =====
// port-level checks for the fraction adder, bound to the top level
`include "fraction_sum_lcd_top_assert.svh"

module fsl_checker (
   input logic                                          clock,
   input logic                                          reset,
   input logic                                          req_valid,
   input logic                                          req_stall,
   input logic signed [fsl_pkg::NUMERATOR_BITS-1:0]     req_first_numerator,
   input logic        [fsl_pkg::DENOMINATOR_BITS-1:0]   req_first_denominator,
   input logic signed [fsl_pkg::NUMERATOR_BITS-1:0]     req_second_numerator,
   input logic        [fsl_pkg::DENOMINATOR_BITS-1:0]   req_second_denominator,
   input logic                                          rsp_valid,
   input logic                                          rsp_stall,
   input logic signed [fsl_pkg::SUM_BITS-1:0]           rsp_sum_numerator,
   input logic        [fsl_pkg::LCD_BITS-1:0]           rsp_common_denominator,
   input logic                                          rsp_zero_denominator_error
);
   import fsl_pkg::*;

   logic req_fire;
   logic zero_in;

   assign req_fire = req_valid && !req_stall;
   assign zero_in  = (req_first_denominator == '0) || (req_second_denominator == '0);

   // a waiting result is not dropped
   `FSL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // the block is busy right after it takes a word
   `FSL_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_fire, req_stall)

   // an error result carries zero values
   `FSL_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_valid && rsp_zero_denominator_error,
      rsp_sum_numerator == '0 && rsp_common_denominator == '0)

   // a good result has a nonzero lcd
   `FSL_ASSERT_IMPLY(a_lcd_nonzero, clock, reset, rsp_valid && !rsp_zero_denominator_error,
      rsp_common_denominator != '0)

   // a result that shows up at the earliest slot after a zero denominator carries the flag
   `FSL_ASSERT_IMPLY(a_err_flag, clock, reset, $rose(rsp_valid) && $past(req_fire && zero_in, 3),
      rsp_zero_denominator_error)

endmodule

bind fraction_sum_lcd_top fsl_checker u_fsl_checker (.*);
